FILE: rtl/upq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upq_pkg
// Shared types and constants of the unsorted array minimum priority queue.
// ----------------------------------------------------------------------------
package upq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VAL_W     = 32;
	localparam int CNT_W     = 7;
	localparam int ST_W      = 2;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	localparam logic signed [VAL_W-1:0] NONE_VALUE = '1;

	typedef struct packed {
		logic                    kind;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic signed [VAL_W-1:0] removed_value;
		logic [CNT_W-1:0]        count;
		logic                    is_empty;
		logic                    is_full;
		logic signed [VAL_W-1:0] first_entry;
		logic signed [VAL_W-1:0] last_entry;
	} rsp_t;

endpackage
`default_nettype wire

FILE: rtl/upq_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upq_mem
// Entry store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module upq_mem
	import upq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                    clk,
	input  wire logic                    we,
	input  wire logic [AW-1:0]           waddr,
	input  wire logic signed [VAL_W-1:0] wdata,
	input  wire logic [AW-1:0]           raddr_a,
	input  wire logic [AW-1:0]           raddr_b,
	output logic signed [VAL_W-1:0]      rdata_a,
	output logic signed [VAL_W-1:0]      rdata_b
);

	logic signed [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

FILE: rtl/upq_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upq_seq
// Sequencer with one shared compare unit: minimum scan, shift down, readout.
// ----------------------------------------------------------------------------
module upq_seq
	import upq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    req_valid,
	input  wire req_t                    req,
	output logic                         ready,
	input  wire logic                    cfg_valid,
	input  wire logic [CNT_W-1:0]        cfg_data,
	output logic                         res_valid,
	output rsp_t                         res,
	input  wire logic                    res_take,
	output logic                         mem_we,
	output logic [AW-1:0]                mem_waddr,
	output logic signed [VAL_W-1:0]      mem_wdata,
	output logic [AW-1:0]                mem_raddr_a,
	output logic [AW-1:0]                mem_raddr_b,
	input  wire logic signed [VAL_W-1:0] mem_rdata_a,
	input  wire logic signed [VAL_W-1:0] mem_rdata_b
);

	localparam int CAP_MAX = (1 << CNT_W) - 1;
	localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'((DEPTH > CAP_MAX) ? CAP_MAX : DEPTH);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_SHIFT = 5'b00100,
		S_RD    = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        cap_q;
	logic [CNT_W-1:0]        ptr_q;
	logic [CNT_W-1:0]        pos_q;
	logic                    vld_s1;
	logic [CNT_W-1:0]        idx_s1;
	logic signed [VAL_W-1:0] best_q;
	logic signed [VAL_W-1:0] removed_q;
	logic [ST_W-1:0]         status_q;

	logic [CNT_W-1:0] eff_cap;
	logic             full;
	logic             accept;
	logic             issue;
	logic             walk_done;
	logic             is_empty;

	assign eff_cap   = (cap_q > CAP_LIM) ? CAP_LIM : cap_q;
	assign full      = (cnt_q >= eff_cap);
	assign ready     = (state_q == S_IDLE);
	assign accept    = ready && req_valid;
	assign issue     = (ptr_q < cnt_q);
	assign walk_done = !issue && !vld_s1;
	assign is_empty  = (cnt_q == '0);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(cnt_q);
		mem_wdata = req.value;
		if (accept && req.kind == KIND_INSERT && !full) begin
			mem_we = 1'b1;
		end else if (state_q == S_SHIFT && vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(idx_s1 - CNT_W'(1));
			mem_wdata = mem_rdata_a;
		end
	end

	assign mem_raddr_a = (state_q == S_RD || state_q == S_RESP) ? '0 : AW'(ptr_q);
	assign mem_raddr_b = is_empty ? '0 : AW'(cnt_q - CNT_W'(1));

	assign res_valid         = (state_q == S_RESP);
	assign res.status        = status_q;
	assign res.removed_value = removed_q;
	assign res.count         = cnt_q;
	assign res.is_empty      = is_empty;
	assign res.is_full       = full;
	assign res.first_entry   = is_empty ? NONE_VALUE : mem_rdata_a;
	assign res.last_entry    = is_empty ? NONE_VALUE : mem_rdata_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.kind == KIND_INSERT) begin
							if (!full) begin
								cnt_q <= cnt_q + CNT_W'(1);
							end
							state_q <= S_RD;
						end else if (is_empty) begin
							state_q <= S_RD;
						end else begin
							ptr_q   <= '0;
							vld_s1  <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					vld_s1 <= issue;
					if (issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (walk_done) begin
						ptr_q   <= pos_q + CNT_W'(1);
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					vld_s1 <= issue;
					if (issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (walk_done) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= ptr_q;
		end
		if (accept) begin
			removed_q <= NONE_VALUE;
			status_q  <= ST_DONE;
			if (req.kind == KIND_INSERT && full) begin
				status_q <= ST_FULL;
			end
			if (req.kind == KIND_REMOVE && is_empty) begin
				status_q <= ST_EMPTY;
			end
		end
		if (state_q == S_SCAN) begin
			if (vld_s1 && (idx_s1 == '0 || mem_rdata_a < best_q)) begin
				best_q <= mem_rdata_a;
				pos_q  <= idx_s1;
			end
			if (walk_done) begin
				removed_q <= best_q;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/unsorted_array_min_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unsorted_array_min_priority_queue
// Minimum priority queue kept as an array in arrival order.
//
// Request channel (req_valid/req_stall/req): kind 0 appends value, kind 1
// removes the smallest entry (oldest among equals). Response channel
// (rsp_valid/rsp_stall/rsp): one response per request with status, removed
// value, count, empty/full flags and the first and last stored entries.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the capacity.
// One request is worked at a time; req_stall is high until it is done.
// Insert or rejected request: after accept the sequencer passes the read and
// response states, and the response is then registered. Remove of n entries:
// one compare per cycle over the n entries, then one shifted entry per cycle
// for the entries after the minimum, then the read and response states.
// Scan and shift both use read port a; only the scan uses the comparator.
// The response sits in an output register; the next request is accepted
// while it waits, and its own response holds until rsp_stall drops.
// Reset empties the queue and sets capacity to 64; entries need no clearing.
// ----------------------------------------------------------------------------
module unsorted_array_min_priority_queue
	import upq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire req_t             req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsp_t                  rsp,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CNT_W-1:0] cfg_data
);

	localparam int AW = $clog2(DEPTH);

	logic                    ready;
	logic                    res_valid;
	rsp_t                    res;
	logic                    res_take;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic signed [VAL_W-1:0] mem_wdata;
	logic [AW-1:0]           mem_raddr_a;
	logic [AW-1:0]           mem_raddr_b;
	logic signed [VAL_W-1:0] mem_rdata_a;
	logic signed [VAL_W-1:0] mem_rdata_b;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	assign req_stall = !ready;
	assign cfg_ready = 1'b1;
	assign res_take  = res_valid && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	upq_seq #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req         (req),
		.ready       (ready),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.res_valid   (res_valid),
		.res         (res),
		.res_take    (res_take),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr_a (mem_raddr_a),
		.mem_raddr_b (mem_raddr_b),
		.mem_rdata_a (mem_rdata_a),
		.mem_rdata_b (mem_rdata_b)
	);

	upq_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

endmodule
`default_nettype wire

FILE: sim/upq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upq_checker
// Watches the request, response and capacity channels of the priority queue,
// keeps its own copy of the stored entries and the capacity, works out the
// response of every accepted request and compares each accepted response,
// field by field, with the oldest one still awaited.
// ----------------------------------------------------------------------------
module upq_checker
	import upq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_stall,
	input  req_t             req,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  rsp_t             rsp,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	output int               in_flight,
	output int               fault_count
);

	logic signed [VAL_W-1:0] held [DEPTH_DEF];
	int                      fill = 0;
	logic [CNT_W-1:0]        cap_setting = CAP_RESET;
	rsp_t                    awaited_outcomes [$];

	initial begin
		in_flight = 0;
		fault_count = 0;
	end

	task automatic report_fault(input string msg);
		$display("%0t checker: %s", $time, msg);
		fault_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_fault($sformatf("%s got %h, want %h", name, got, want));
	endtask

	function automatic rsp_t queue_outcome(input req_t r);
		rsp_t o;
		int   limit;
		int   pos;
		limit = (cap_setting > DEPTH_DEF) ? DEPTH_DEF : int'(cap_setting);
		o.status = ST_DONE;
		o.removed_value = NONE_VALUE;
		if (r.kind == KIND_INSERT) begin
			if (fill >= limit) begin
				o.status = ST_FULL;
			end else begin
				held[fill] = r.value;
				fill++;
			end
		end else if (fill == 0) begin
			o.status = ST_EMPTY;
		end else begin
			pos = 0;
			for (int i = 1; i < fill; i++)
				if (held[i] < held[pos])
					pos = i;
			o.removed_value = held[pos];
			for (int i = pos; i < fill - 1; i++)
				held[i] = held[i + 1];
			fill--;
		end
		o.count = CNT_W'(fill);
		o.is_empty = (fill == 0);
		o.is_full = (fill >= limit);
		o.first_entry = (fill == 0) ? NONE_VALUE : held[0];
		o.last_entry = (fill == 0) ? NONE_VALUE : held[fill - 1];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			cap_setting = CAP_RESET;
			awaited_outcomes.delete();
			in_flight <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_outcomes.size() == 0) begin
					report_fault("response with no request outstanding");
				end else begin
					check_field("status", rsp.status, awaited_outcomes[0].status);
					check_field("removed_value", rsp.removed_value,
						awaited_outcomes[0].removed_value);
					check_field("count", rsp.count, awaited_outcomes[0].count);
					check_field("is_empty", rsp.is_empty, awaited_outcomes[0].is_empty);
					check_field("is_full", rsp.is_full, awaited_outcomes[0].is_full);
					check_field("first_entry", rsp.first_entry,
						awaited_outcomes[0].first_entry);
					check_field("last_entry", rsp.last_entry,
						awaited_outcomes[0].last_entry);
					void'(awaited_outcomes.pop_front());
				end
			end
			if (cfg_valid && cfg_ready)
				cap_setting = cfg_data;
			if (req_valid && !req_stall)
				awaited_outcomes.push_back(queue_outcome(req));
			in_flight <= awaited_outcomes.size();
		end
	end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the priority queue with a directed opening (empty removes, ties at
// the largest value, extreme values, zero and one capacity) and then random
// phases, each under a new capacity, with random idling on both channels save
// in one calm phase. The checker beside the block judges every response.
// ----------------------------------------------------------------------------
module tb_top;
	import upq_pkg::*;

	localparam int CYCLE_LIMIT  = 600_000;
	localparam int DRAIN_CYCLES = 2 * DEPTH_DEF + 16;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	req_t             req = '0;
	logic             rsp_stall = 1'b0;
	logic             cfg_valid = 1'b0;
	logic [CNT_W-1:0] cfg_data = '0;
	logic             calm = 1'b0;
	logic             req_stall;
	logic             rsp_valid;
	logic             cfg_ready;
	rsp_t             rsp;
	int               in_flight;
	int               fault_count;
	int               cycles = 0;

	unsorted_array_min_priority_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	upq_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_flight   (in_flight),
		.fault_count (fault_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		rsp_stall <= !calm && ($urandom_range(99) < 36);
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return NONE_VALUE;
			3: return '0;
			4, 5: return $signed(VAL_W'($urandom_range(8))) - 4;
			default: return $urandom;
		endcase
	endfunction

	task automatic issue(input logic kind, input logic signed [VAL_W-1:0] value);
		while (!calm && $urandom_range(99) < 36) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{kind: kind, value: value};
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (in_flight != 0);
	endtask

	task automatic set_capacity(input logic [CNT_W-1:0] cap_value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= cap_value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [CNT_W-1:0] cap_value, input int items,
			input int insert_pct, input logic quiet);
		calm <= quiet;
		set_capacity(cap_value);
		repeat (items)
			issue(($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE,
				pick_value());
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(KIND_REMOVE, VAL_MAX);
		repeat (3) issue(KIND_INSERT, VAL_MAX);
		repeat (3) issue(KIND_REMOVE, '0);
		issue(KIND_INSERT, VAL_MIN);
		issue(KIND_INSERT, '0);
		issue(KIND_INSERT, NONE_VALUE);
		issue(KIND_INSERT, 1);
		issue(KIND_INSERT, VAL_MIN);
		repeat (6) issue(KIND_REMOVE, NONE_VALUE);

		set_capacity(0);
		issue(KIND_INSERT, 5);
		issue(KIND_REMOVE, 5);
		set_capacity(1);
		issue(KIND_INSERT, VAL_MAX);
		issue(KIND_INSERT, 7);

		run_phase(127, 100, 90, 1'b0);
		run_phase(3, 60, 30, 1'b0);
		run_phase(64, 70, 20, 1'b0);
		run_phase(0, 40, 50, 1'b0);
		run_phase(CNT_W'($urandom_range(127, 1)), 100, 60, 1'b1);
		run_phase(2, 60, 55, 1'b0);
		run_phase(64, 80, 70, 1'b0);
		run_phase(CNT_W'($urandom_range(127, 1)), 80, 45, 1'b0);
		run_phase(1, 40, 50, 1'b0);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
